>>> rtl/keyvalues_text_tokenizer_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the key/value tokenizer
// ---------------------------------------------------------------------------
`ifndef KEYVALUES_TEXT_TOKENIZER_CORE_MACROS_SVH
`define KEYVALUES_TEXT_TOKENIZER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define KVT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KVT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KVT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define KVT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/kvt_pkg.sv
// ---------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants of the key/value text tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none
package kvt_pkg;
    localparam int TOKEN_MAX_DEF = 512;
    localparam int NEST_MAX_DEF  = 255;

    typedef enum logic [3:0] {
        S_OK, S_OK_SL, S_ID, S_ID_SL, S_IDQ, S_SEP, S_SEP_SL, S_CSEP, S_CSEP_SL,
        S_CPRE, S_VAL, S_VAL_SL, S_VALQ, S_AFTER, S_AFTER_SL, S_CSUF
    } gstate_t;

    typedef enum logic [2:0] {
        EV_BYTE = 3'd0, EV_TEND = 3'd1, EV_NOPEN = 3'd2, EV_NCLOSE = 3'd3,
        EV_DONE = 3'd4, EV_ERR = 3'd5
    } event_t;

    localparam logic [2:0] TK_ID = 3'd0, TK_IDQ = 3'd1, TK_VAL = 3'd2,
                           TK_VALQ = 3'd3, TK_PRE = 3'd4, TK_SUF = 3'd5;

    localparam logic [4:0] E_MACRO = 5'd0, E_OPEN_KEY = 5'd1, E_CLOSE_MANY = 5'd2,
        E_CLOSE_UNEXP = 5'd3, E_BRACKET_UNEXP = 5'd4, E_QUOTE_UNEXP = 5'd5,
        E_COND_WS = 5'd6, E_COND_BRACKET = 5'd7, E_COND_BRACE = 5'd8,
        E_COND_SLASH = 5'd9, E_KEY_BRACKET = 5'd10, E_PRE_BRACKET = 5'd11,
        E_PRE_STRING = 5'd12, E_VAL_BRACE = 5'd13, E_TOO_LONG = 5'd14,
        E_EOF = 5'd15, E_NEST = 5'd16;

    localparam logic [7:0] C_LBRACE = 8'h7B, C_RBRACE = 8'h7D, C_LBRACK = 8'h5B,
        C_RBRACK = 8'h5D, C_QUOTE = 8'h22, C_SLASH = 8'h2F, C_HASH = 8'h23,
        C_NL = 8'h0A, C_TAB = 8'h09, C_CR = 8'h0D, C_SP = 8'h20;

    typedef struct packed {
        logic [2:0]  ev;
        logic [2:0]  tk;
        logic [7:0]  b;
        logic [4:0]  err;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } res_t;

    // classified request handed from front to back
    typedef struct packed {
        logic   two;
        res_t   r0;
        res_t   r1;
    } pair_t;
endpackage
`default_nettype wire

>>> rtl/kvt_front.sv
// ---------------------------------------------------------------------------
// kvt_front
// Grammar state machine: classifies one request per cycle into 0..2 results.
// ---------------------------------------------------------------------------
`default_nettype none
module kvt_front import kvt_pkg::*; #(
    parameter int TOKEN_MAX = TOKEN_MAX_DEF,
    parameter int NEST_MAX  = NEST_MAX_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_end,
    output pair_t           pr,
    output logic            pr_cnt_nz
);
    gstate_t     st_reg, st_next;
    logic        cm_reg, cm_next;
    logic [7:0]  nl_reg, nl_next;
    logic [9:0]  tl_reg, tl_next;
    logic [15:0] ln_reg, ln_next, co_reg, co_next;
    logic        f_reg, f_next;
    logic [4:0]  fc_reg, fc_next;

    res_t r [2];
    logic [1:0] n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_OK; cm_reg <= 1'b0; nl_reg <= '0; tl_reg <= '0;
            ln_reg <= 16'd1; co_reg <= '0; f_reg <= 1'b0; fc_reg <= '0;
        end else if (in_valid) begin
            st_reg <= st_next; cm_reg <= cm_next; nl_reg <= nl_next; tl_reg <= tl_next;
            ln_reg <= ln_next; co_reg <= co_next; f_reg <= f_next; fc_reg <= fc_next;
        end
    end

    always_comb begin
        logic ws;
        logic [7:0] c;
        c = in_byte;
        ws = (c == C_SP) || (c == C_TAB) || (c == C_NL) || (c == C_CR);
        st_next = st_reg; cm_next = cm_reg; nl_next = nl_reg; tl_next = tl_reg;
        ln_next = ln_reg; co_next = co_reg; f_next = f_reg; fc_next = fc_reg;
        n = 2'd0;
        r[0] = '0; r[1] = '0;

        if (f_reg) begin
            r[0].ev = EV_ERR; r[0].err = fc_reg; r[0].line = ln_reg; r[0].col = co_reg;
            n = 2'd1;
        end else if (in_end) begin
            r[0].line = ln_reg; r[0].col = co_reg; n = 2'd1;
            if (st_reg != S_OK && st_reg != S_AFTER) begin
                r[0].ev = EV_ERR; r[0].err = E_EOF; f_next = 1'b1; fc_next = E_EOF;
            end else if (nl_reg != 8'd0) begin
                r[0].ev = EV_ERR; r[0].err = E_NEST; f_next = 1'b1; fc_next = E_NEST;
            end else begin
                r[0].ev = EV_DONE;
            end
        end else begin
            if (c == C_NL) begin
                if (ln_reg != 16'hFFFF) ln_next = ln_reg + 16'd1;
                co_next = '0;
            end else if (co_reg != 16'hFFFF) begin
                co_next = co_reg + 16'd1;
            end
            if (cm_reg) begin
                if (c == C_NL) cm_next = 1'b0;
            end else begin
                // ops: sequence of micro actions, processed in order
                logic [2:0] tk;
                logic do_e1, do_e2, do_end, do_open, do_close, do_fail;
                logic [7:0] b1;
                logic [4:0] fcode;
                logic [2:0] etk;
                tk = TK_ID; etk = TK_ID; b1 = c; fcode = '0;
                do_e1 = 0; do_e2 = 0; do_end = 0; do_open = 0; do_close = 0; do_fail = 0;
                case (st_reg)
                    S_OK, S_AFTER: begin
                        if (ws) st_next = S_OK;
                        else if (st_reg == S_AFTER && c == C_LBRACK) st_next = S_CSUF;
                        else if (st_reg == S_AFTER && c == C_SLASH) st_next = S_AFTER_SL;
                        else case (c)
                            C_HASH: begin do_fail = 1; fcode = E_MACRO; end
                            C_LBRACE: begin do_fail = 1; fcode = E_OPEN_KEY; end
                            C_RBRACE: begin do_close = 1; st_next = S_OK; end
                            C_QUOTE: st_next = S_IDQ;
                            C_SLASH: st_next = S_OK_SL;
                            C_LBRACK, C_RBRACK: begin do_fail = 1; fcode = E_KEY_BRACKET; end
                            default: begin do_e2 = 1; tk = TK_ID; st_next = S_ID; end
                        endcase
                        if (st_reg == S_AFTER && ws) st_next = S_AFTER;
                    end
                    S_OK_SL, S_AFTER_SL, S_SEP_SL, S_ID_SL, S_VAL_SL: begin
                        tk = (st_reg == S_SEP_SL || st_reg == S_VAL_SL) ? TK_VAL : TK_ID;
                        if (c == C_SLASH) begin
                            cm_next = 1'b1;
                            case (st_reg)
                                S_OK_SL: st_next = S_OK;
                                S_AFTER_SL: st_next = S_AFTER;
                                S_SEP_SL: st_next = S_SEP;
                                S_ID_SL: begin do_end = 1; etk = TK_ID; st_next = S_SEP; end
                                default: begin do_end = 1; etk = TK_VAL; st_next = S_AFTER; end
                            endcase
                        end else begin
                            do_e1 = 1; do_e2 = 1;
                            st_next = (tk == TK_VAL) ? S_VAL : S_ID;
                        end
                    end
                    S_ID: begin
                        if (ws) begin do_end = 1; etk = TK_ID; st_next = S_SEP; end
                        else case (c)
                            C_LBRACE: begin do_end = 1; etk = TK_ID; do_open = 1; end
                            C_LBRACK: begin do_end = 1; etk = TK_ID; st_next = S_CPRE; end
                            C_RBRACE: begin do_fail = 1; fcode = E_CLOSE_UNEXP; end
                            C_RBRACK: begin do_fail = 1; fcode = E_BRACKET_UNEXP; end
                            C_QUOTE: begin do_fail = 1; fcode = E_QUOTE_UNEXP; end
                            C_SLASH: st_next = S_ID_SL;
                            default: begin do_e2 = 1; tk = TK_ID; end
                        endcase
                    end
                    S_IDQ, S_VALQ: begin
                        etk = (st_reg == S_IDQ) ? TK_IDQ : TK_VALQ;
                        if (c == C_QUOTE) begin
                            do_end = 1; st_next = (st_reg == S_IDQ) ? S_SEP : S_AFTER;
                        end else begin do_e2 = 1; tk = etk; end
                    end
                    S_SEP: begin
                        if (!ws) case (c)
                            C_LBRACE: do_open = 1;
                            C_LBRACK: st_next = S_CPRE;
                            C_QUOTE: st_next = S_VALQ;
                            C_RBRACE: begin do_fail = 1; fcode = E_CLOSE_UNEXP; end
                            C_RBRACK: begin do_fail = 1; fcode = E_BRACKET_UNEXP; end
                            C_SLASH: st_next = S_SEP_SL;
                            default: begin do_e2 = 1; tk = TK_VAL; st_next = S_VAL; end
                        endcase
                    end
                    S_CPRE, S_CSUF: begin
                        etk = (st_reg == S_CPRE) ? TK_PRE : TK_SUF;
                        if (ws) begin do_fail = 1; fcode = E_COND_WS; end
                        else case (c)
                            C_LBRACK: begin do_fail = 1; fcode = E_COND_BRACKET; end
                            C_LBRACE, C_RBRACE: begin do_fail = 1; fcode = E_COND_BRACE; end
                            C_SLASH: begin do_fail = 1; fcode = E_COND_SLASH; end
                            C_RBRACK: begin
                                do_end = 1; st_next = (st_reg == S_CPRE) ? S_CSEP : S_OK;
                            end
                            default: begin do_e2 = 1; tk = etk; end
                        endcase
                    end
                    S_CSEP: begin
                        if (!ws) case (c)
                            C_LBRACE: do_open = 1;
                            C_RBRACE: begin do_fail = 1; fcode = E_CLOSE_UNEXP; end
                            C_LBRACK: begin do_fail = 1; fcode = E_PRE_BRACKET; end
                            C_RBRACK: begin do_fail = 1; fcode = E_BRACKET_UNEXP; end
                            C_SLASH: st_next = S_CSEP_SL;
                            default: begin do_fail = 1; fcode = E_PRE_STRING; end
                        endcase
                    end
                    S_CSEP_SL: begin
                        if (c == C_SLASH) begin cm_next = 1'b1; st_next = S_CSEP; end
                        else begin do_fail = 1; fcode = E_PRE_STRING; end
                    end
                    S_VAL: begin
                        etk = TK_VAL;
                        if (ws) begin do_end = 1; st_next = S_AFTER; end
                        else case (c)
                            C_LBRACE: begin do_fail = 1; fcode = E_VAL_BRACE; end
                            C_RBRACK: begin do_fail = 1; fcode = E_BRACKET_UNEXP; end
                            C_QUOTE: begin do_fail = 1; fcode = E_QUOTE_UNEXP; end
                            C_RBRACE: begin do_end = 1; do_close = 1; st_next = S_AFTER; end
                            C_LBRACK: begin do_end = 1; st_next = S_CSUF; end
                            C_SLASH: st_next = S_VAL_SL;
                            default: begin do_e2 = 1; tk = TK_VAL; end
                        endcase
                    end
                    default: ;
                endcase

                // execute in order: emit '/', emit c | tok_end, open/close, fail
                if (do_e1) begin
                    if (tl_next >= 10'(TOKEN_MAX)) begin
                        do_e2 = 0; do_fail = 1; fcode = E_TOO_LONG;
                    end else begin
                        r[n[0]] = '0; r[n[0]].ev = EV_BYTE; r[n[0]].tk = tk;
                        r[n[0]].b = C_SLASH;
                        n = n + 2'd1; tl_next = tl_next + 10'd1;
                    end
                end
                if (do_e2) begin
                    if (tl_next >= 10'(TOKEN_MAX)) begin
                        do_fail = 1; fcode = E_TOO_LONG;
                    end else begin
                        r[n[0]] = '0; r[n[0]].ev = EV_BYTE; r[n[0]].tk = tk; r[n[0]].b = b1;
                        n = n + 2'd1; tl_next = tl_next + 10'd1;
                    end
                end
                if (do_end) begin
                    r[n[0]] = '0; r[n[0]].ev = EV_TEND; r[n[0]].tk = etk;
                    n = n + 2'd1; tl_next = '0;
                end
                if (do_open) begin
                    if (nl_reg >= 8'(NEST_MAX)) begin do_fail = 1; fcode = E_NEST; end
                    else begin
                        nl_next = nl_reg + 8'd1; st_next = S_OK;
                        r[n[0]] = '0; r[n[0]].ev = EV_NOPEN; r[n[0]].b = C_LBRACE;
                        n = n + 2'd1;
                    end
                end
                if (do_close) begin
                    if (nl_reg == 8'd0) begin
                        do_fail = 1; fcode = E_CLOSE_MANY; st_next = st_reg;
                        if (st_reg == S_VAL) st_next = S_VAL;
                    end else begin
                        nl_next = nl_reg - 8'd1;
                        r[n[0]] = '0; r[n[0]].ev = EV_NCLOSE; r[n[0]].b = C_RBRACE;
                        n = n + 2'd1;
                    end
                end
                if (do_fail) begin
                    f_next = 1'b1; fc_next = fcode;
                    r[n[0]] = '0; r[n[0]].ev = EV_ERR; r[n[0]].err = fcode;
                    n = n + 2'd1;
                end
            end
            r[0].line = ln_next; r[0].col = co_next;
            r[1].line = ln_next; r[1].col = co_next;
        end
        if (n == 2'd2) r[1].last = 1'b1;
        else r[0].last = 1'b1;
        pr.two = (n == 2'd2);
        pr.r0 = r[0];
        pr.r1 = r[1];
        pr_cnt_nz = (n != 2'd0);
    end
endmodule
`default_nettype wire

>>> rtl/kvt_back.sv
// ---------------------------------------------------------------------------
// kvt_back
// Result queue: stores results and drains them one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none
`include "keyvalues_text_tokenizer_core_macros.svh"
module kvt_back import kvt_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire logic  push_nz,
    input  wire pair_t pr,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output res_t       out_res
);
    localparam int DEPTH = 4;
    res_t       mem [DEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] nin;

    assign pop = out_valid && out_ready;
    assign nin = !(push && push_nz) ? 2'd0 : (pr.two ? 2'd2 : 2'd1);
    assign cnt_next = cnt_reg + 3'(nin) - 3'(pop);
    assign room = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_res = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            wp_reg <= wp_reg + nin;
            rp_reg <= rp_reg + 2'(pop);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (nin != 2'd0) mem[wp_reg] <= pr.r0;
        if (nin == 2'd2) mem[wp_reg + 2'd1] <= pr.r1;
    end

    `KVT_ASSERT_IMP(a_no_overflow, aclk, aresetn, 1'b1, cnt_reg <= 3'(DEPTH))
    `KVT_ASSERT_IMP(a_push_room, aclk, aresetn, push, room)
    `KVT_ASSERT_NXT(a_cnt_track, aclk, aresetn, pop && nin == 2'd0, cnt_reg == $past(cnt_reg) - 3'd1)
endmodule
`default_nettype wire

>>> rtl/keyvalues_text_tokenizer_core.sv
// Latency: with the result queue empty, a request's first result is offered the cycle after it is accepted.
// Throughput: one request per cycle while the result queue has room; a request yields up
// to two results and the output drains one per cycle while m_tready is high, so a long
// run of two-result requests halves it. The four-entry result queue sets that figure.
// Reset: synchronous, active low; grammar at key level, line 1, column 0.
// ---------------------------------------------------------------------------
// keyvalues_text_tokenizer_core
// Streaming key/value text tokenizer: grammar front end and result queue.
// ---------------------------------------------------------------------------
`default_nettype none
module keyvalues_text_tokenizer_core import kvt_pkg::*; #(
    parameter int TOKEN_MAX = TOKEN_MAX_DEF,
    parameter int NEST_MAX  = NEST_MAX_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // text_byte
    input  wire logic        s_tlast,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // out_byte, error_code, line_at, column_at,
                                        // zero pad
    output logic [5:0]       m_tuser,   // event_kind, token_kind
    output logic             m_tlast    // last_of_item
);
    pair_t pr;
    logic  nz, room, acc;
    res_t  o;

    assign s_tready = room;
    assign acc = s_tvalid && s_tready;

    kvt_front #(.TOKEN_MAX(TOKEN_MAX), .NEST_MAX(NEST_MAX)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(acc), .in_byte(s_tdata),
        .in_end(s_tlast), .pr(pr), .pr_cnt_nz(nz)
    );

    kvt_back u_back (
        .aclk(aclk), .aresetn(aresetn), .push(acc), .push_nz(nz), .pr(pr),
        .room(room), .out_valid(m_tvalid), .out_ready(m_tready), .out_res(o)
    );

    assign m_tdata = {3'd0, o.col, o.line, o.err, o.b};
    assign m_tuser = {o.tk, o.ev};
    assign m_tlast = o.last;
endmodule
`default_nettype wire

>>> bench/keyvalues_text_tokenizer_core_tb.sv
// ---------------------------------------------------------------------------
// keyvalues_text_tokenizer_core_tb
// Drives text bytes and end marks into the tokenizer, predicts each token,
// nest, done and error event, and checks every result field by field.
// Grammar-aware random text keeps the block out of the sticky error state
// until a final test that forces one error.
// ---------------------------------------------------------------------------
`default_nettype none
module keyvalues_text_tokenizer_core_tb;
    import kvt_pkg::*;

    localparam int LIMIT = 200000;

    typedef struct {
        gstate_t     gs;
        bit          cmt;
        int unsigned nest;
        int unsigned tlen;
        int unsigned line;
        int unsigned col;
        bit          failed;
        logic [4:0]  code;
    } scan_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        m_tlast;

    scan_t scan;
    res_t  pending_events[$];
    int    mismatches = 0;
    int    cycles = 0;
    bit    tx_idle = 1;
    bit    rx_idle = 1;
    bit    hold_go = 0;

    keyvalues_text_tokenizer_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // ---------------- event predictor ----------------
    function automatic bit is_ws(input logic [7:0] c);
        return c == C_SP || c == C_TAB || c == C_NL || c == C_CR;
    endfunction

    function automatic void put(ref scan_t s, ref res_t o[$], input logic [2:0] ev,
                                input logic [2:0] tk, input logic [7:0] b,
                                input logic [4:0] e);
        res_t r;
        if (o.size() >= 2) return;
        r.ev = ev; r.tk = tk; r.b = b; r.err = e;
        r.line = s.line[15:0]; r.col = s.col[15:0]; r.last = 1'b0;
        o.push_back(r);
    endfunction

    function automatic void fail(ref scan_t s, ref res_t o[$], input logic [4:0] e);
        s.failed = 1;
        s.code = e;
        put(s, o, EV_ERR, 0, 0, e);
    endfunction

    function automatic void emit(ref scan_t s, ref res_t o[$], input logic [2:0] tk,
                                 input logic [7:0] b);
        if (s.failed) return;
        if (s.tlen >= TOKEN_MAX_DEF) begin
            fail(s, o, E_TOO_LONG);
            return;
        end
        put(s, o, EV_BYTE, tk, b, 0);
        s.tlen = (s.tlen + 1) & 10'h3FF;
    endfunction

    function automatic void tok_end(ref scan_t s, ref res_t o[$], input logic [2:0] tk);
        put(s, o, EV_TEND, tk, 0, 0);
        s.tlen = 0;
    endfunction

    function automatic void open_nest(ref scan_t s, ref res_t o[$]);
        if (s.nest >= NEST_MAX_DEF) begin
            fail(s, o, E_NEST);
            return;
        end
        s.nest++;
        put(s, o, EV_NOPEN, 0, C_LBRACE, 0);
        s.gs = S_OK;
    endfunction

    function automatic void slash_pair(ref scan_t s, ref res_t o[$], input logic [2:0] tk,
                                       input logic [7:0] c, input gstate_t nxt);
        emit(s, o, tk, C_SLASH);
        emit(s, o, tk, c);
        s.gs = nxt;
    endfunction

    function automatic void key_level(ref scan_t s, ref res_t o[$], input logic [7:0] c);
        if (is_ws(c)) begin
            s.gs = S_OK;
            return;
        end
        case (c)
            C_HASH: fail(s, o, E_MACRO);
            C_LBRACE: fail(s, o, E_OPEN_KEY);
            C_RBRACE: begin
                if (s.nest == 0) fail(s, o, E_CLOSE_MANY);
                else begin
                    s.nest--;
                    put(s, o, EV_NCLOSE, 0, C_RBRACE, 0);
                    s.gs = S_OK;
                end
            end
            C_QUOTE: s.gs = S_IDQ;
            C_SLASH: s.gs = S_OK_SL;
            C_LBRACK, C_RBRACK: fail(s, o, E_KEY_BRACKET);
            default: begin
                emit(s, o, TK_ID, c);
                s.gs = S_ID;
            end
        endcase
    endfunction

    function automatic void cond_byte(ref scan_t s, ref res_t o[$], input logic [7:0] c,
                                      input logic [2:0] tk, input gstate_t nxt);
        if (is_ws(c)) begin
            fail(s, o, E_COND_WS);
            return;
        end
        case (c)
            C_LBRACK: fail(s, o, E_COND_BRACKET);
            C_LBRACE, C_RBRACE: fail(s, o, E_COND_BRACE);
            C_SLASH: fail(s, o, E_COND_SLASH);
            C_RBRACK: begin
                tok_end(s, o, tk);
                s.gs = nxt;
            end
            default: emit(s, o, tk, c);
        endcase
    endfunction

    function automatic void to_comment(ref scan_t s, input gstate_t nxt);
        s.cmt = 1;
        s.gs = nxt;
    endfunction

    function automatic void parse_byte(ref scan_t s, ref res_t o[$], input logic [7:0] c);
        case (s.gs)
            S_OK: key_level(s, o, c);
            S_OK_SL:
                if (c == C_SLASH) to_comment(s, S_OK);
                else slash_pair(s, o, TK_ID, c, S_ID);
            S_ID: begin
                if (is_ws(c)) begin
                    tok_end(s, o, TK_ID);
                    s.gs = S_SEP;
                end else case (c)
                    C_LBRACE: begin
                        tok_end(s, o, TK_ID);
                        open_nest(s, o);
                    end
                    C_LBRACK: begin
                        tok_end(s, o, TK_ID);
                        s.gs = S_CPRE;
                    end
                    C_RBRACE: fail(s, o, E_CLOSE_UNEXP);
                    C_RBRACK: fail(s, o, E_BRACKET_UNEXP);
                    C_QUOTE: fail(s, o, E_QUOTE_UNEXP);
                    C_SLASH: s.gs = S_ID_SL;
                    default: emit(s, o, TK_ID, c);
                endcase
            end
            S_ID_SL:
                if (c == C_SLASH) begin
                    tok_end(s, o, TK_ID);
                    to_comment(s, S_SEP);
                end else slash_pair(s, o, TK_ID, c, S_ID);
            S_IDQ:
                if (c == C_QUOTE) begin
                    tok_end(s, o, TK_IDQ);
                    s.gs = S_SEP;
                end else emit(s, o, TK_IDQ, c);
            S_SEP:
                if (!is_ws(c)) case (c)
                    C_LBRACE: open_nest(s, o);
                    C_LBRACK: s.gs = S_CPRE;
                    C_QUOTE: s.gs = S_VALQ;
                    C_RBRACE: fail(s, o, E_CLOSE_UNEXP);
                    C_RBRACK: fail(s, o, E_BRACKET_UNEXP);
                    C_SLASH: s.gs = S_SEP_SL;
                    default: begin
                        emit(s, o, TK_VAL, c);
                        s.gs = S_VAL;
                    end
                endcase
            S_SEP_SL:
                if (c == C_SLASH) to_comment(s, S_SEP);
                else slash_pair(s, o, TK_VAL, c, S_VAL);
            S_CPRE: cond_byte(s, o, c, TK_PRE, S_CSEP);
            S_CSEP:
                if (!is_ws(c)) case (c)
                    C_LBRACE: open_nest(s, o);
                    C_RBRACE: fail(s, o, E_CLOSE_UNEXP);
                    C_LBRACK: fail(s, o, E_PRE_BRACKET);
                    C_RBRACK: fail(s, o, E_BRACKET_UNEXP);
                    C_SLASH: s.gs = S_CSEP_SL;
                    default: fail(s, o, E_PRE_STRING);
                endcase
            S_CSEP_SL:
                if (c == C_SLASH) to_comment(s, S_CSEP);
                else fail(s, o, E_PRE_STRING);
            S_VAL: begin
                if (is_ws(c)) begin
                    tok_end(s, o, TK_VAL);
                    s.gs = S_AFTER;
                end else case (c)
                    C_LBRACE: fail(s, o, E_VAL_BRACE);
                    C_RBRACK: fail(s, o, E_BRACKET_UNEXP);
                    C_QUOTE: fail(s, o, E_QUOTE_UNEXP);
                    C_RBRACE: begin
                        // token end goes out before the close or its error
                        tok_end(s, o, TK_VAL);
                        if (s.nest == 0) fail(s, o, E_CLOSE_MANY);
                        else begin
                            s.nest--;
                            put(s, o, EV_NCLOSE, 0, C_RBRACE, 0);
                            s.gs = S_AFTER;
                        end
                    end
                    C_LBRACK: begin
                        tok_end(s, o, TK_VAL);
                        s.gs = S_CSUF;
                    end
                    C_SLASH: s.gs = S_VAL_SL;
                    default: emit(s, o, TK_VAL, c);
                endcase
            end
            S_VAL_SL:
                if (c == C_SLASH) begin
                    tok_end(s, o, TK_VAL);
                    to_comment(s, S_AFTER);
                end else slash_pair(s, o, TK_VAL, c, S_VAL);
            S_VALQ:
                if (c == C_QUOTE) begin
                    tok_end(s, o, TK_VALQ);
                    s.gs = S_AFTER;
                end else emit(s, o, TK_VALQ, c);
            S_AFTER:
                if (!is_ws(c)) begin
                    if (c == C_LBRACK) s.gs = S_CSUF;
                    else if (c == C_SLASH) s.gs = S_AFTER_SL;
                    else key_level(s, o, c);
                end
            S_AFTER_SL:
                if (c == C_SLASH) to_comment(s, S_AFTER);
                else slash_pair(s, o, TK_ID, c, S_ID);
            default: cond_byte(s, o, c, TK_SUF, S_OK);
        endcase
    endfunction

    function automatic void tokenize(ref scan_t s, input logic [7:0] c, input bit eoi,
                                     ref res_t o[$]);
        o.delete();
        if (s.failed) put(s, o, EV_ERR, 0, 0, s.code);
        else if (eoi) begin
            if (s.gs != S_OK && s.gs != S_AFTER) fail(s, o, E_EOF);
            else if (s.nest != 0) fail(s, o, E_NEST);
            else put(s, o, EV_DONE, 0, 0, 0);
        end else begin
            if (c == C_NL) begin
                if (s.line < 16'hFFFF) s.line++;
                s.col = 0;
            end else if (s.col < 16'hFFFF) s.col++;
            if (s.cmt) begin
                if (c == C_NL) s.cmt = 0;
            end else parse_byte(s, o, c);
        end
        if (o.size() > 0) o[o.size() - 1].last = 1'b1;
    endfunction

    // ---------------- stimulus ----------------
    function automatic logic [7:0] any_byte();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 8'h61 + 8'($urandom_range(25));
        if (r < 55) begin
            case ($urandom_range(3))
                0: return C_SP;
                1: return C_TAB;
                2: return C_CR;
                default: return C_NL;
            endcase
        end
        if (r < 63) return $urandom_range(1) ? C_LBRACE : C_RBRACE;
        if (r < 70) return C_QUOTE;
        if (r < 76) return $urandom_range(1) ? C_LBRACK : C_RBRACK;
        if (r < 84) return C_SLASH;
        return 8'($urandom_range(255));
    endfunction

    // true when the item keeps the scanner out of the error state and nesting below 200
    function automatic bit keeps_going(input logic [7:0] c, input bit eoi);
        scan_t t;
        res_t  o[$];
        t = scan;
        tokenize(t, c, eoi, o);
        return !t.failed && t.nest < 200;
    endfunction

    task automatic send_item(input logic [7:0] c, input bit eoi);
        res_t o[$];
        while (tx_idle && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tokenize(scan, c, eoi, o);
        foreach (o[i]) pending_events.push_back(o[i]);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_item(txt[i], 1'b0);
    endtask

    task automatic send_wellformed(input int n);
        logic [7:0] c;
        bit         eoi;
        int         k;
        for (int i = 0; i < n; i++) begin
            k = 0;
            do begin
                eoi = ($urandom_range(99) < 4);
                c   = eoi ? 8'($urandom_range(255)) : any_byte();
                k++;
            end while (!keeps_going(c, eoi) && k < 200);
            if (!keeps_going(c, eoi)) begin
                eoi = 0;
                for (int b = 0; b < 256; b++)
                    if (keeps_going(8'(b), 0)) begin
                        c = 8'(b);
                        break;
                    end
            end
            send_item(c, eoi);
        end
    endtask

    task automatic test_directed();
        // lone slash with whitespace, quoted key, prefix cond, bare value
        // closed by brace, suffix cond, line comment, end check
        send_text({"a/ {\"q\"[p]{k v}} b/c \"v\"[s]//x", 8'h0A});
        send_item(8'hA5, 1'b1);
    endtask

    task automatic test_random_text();
        send_wellformed(450);
        tx_idle = 0;
        rx_idle = 0;
        send_wellformed(200);
        tx_idle = 1;
        rx_idle = 1;
        send_wellformed(200);
    endtask

    task automatic test_backpressure();
        hold_go = 1;
        send_wellformed(60);
    endtask

    task automatic test_sticky_error();
        logic [7:0] c;
        bit         eoi;
        do begin
            eoi = ($urandom_range(99) < 10);
            c   = eoi ? 8'h00 : any_byte();
        end while (keeps_going(c, eoi));
        send_item(c, eoi);
        for (int i = 0; i < 8; i++) send_item(8'($urandom_range(255)), $urandom_range(1));
    endtask

    // ---------------- result side ----------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_go = 0;
            end
            m_tready <= !(rx_idle && $urandom_range(99) < 10);
        end
    end

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        $display("mismatch %s: expected %0h got %0h", what, want, got);
    endtask

    always @(posedge aclk) begin
        res_t want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) report("unexpected result", 0, m_tdata[31:0]);
            else begin
                want = pending_events.pop_front();
                if (m_tuser[2:0] != want.ev) report("event_kind", want.ev, m_tuser[2:0]);
                if (m_tuser[5:3] != want.tk) report("token_kind", want.tk, m_tuser[5:3]);
                if (m_tdata[7:0] != want.b) report("out_byte", want.b, m_tdata[7:0]);
                if (m_tdata[12:8] != want.err) report("error_code", want.err, m_tdata[12:8]);
                if (m_tdata[28:13] != want.line) report("line_at", want.line, m_tdata[28:13]);
                if (m_tdata[44:29] != want.col) report("column_at", want.col, m_tdata[44:29]);
                if (m_tlast != want.last) report("last_of_item", want.last, m_tlast);
            end
        end
    end

    initial begin
        scan = '{gs: S_OK, cmt: 0, nest: 0, tlen: 0, line: 1, col: 0, failed: 0, code: 0};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_text();
        test_backpressure();
        test_sticky_error();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
